// ----- sv/cfpi_pkg.sv -----
`timescale 1ns / 1ps

package cfpi_pkg;

  // Bus commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic REG_BOOT_DELAY   = 1'b0;
  localparam logic REG_IRQ_INTERVAL = 1'b1;

  // Register offsets inside the device window
  localparam logic [11:0] OFS_STAT   = 12'h004;
  localparam logic [11:0] OFS_PTR_LO = 12'h008;
  localparam logic [11:0] OFS_PTR_HI = 12'h009;
  localparam logic [11:0] OFS_PAR_LO = 12'h010;
  localparam logic [11:0] OFS_PAR_HI = 12'h011;
  localparam logic [11:0] OFS_FST_LO = 12'h012;
  localparam logic [11:0] OFS_FST_HI = 12'h013;
  localparam logic [11:0] WIN_WR_LO  = 12'h100;
  localparam logic [11:0] WIN_WR_HI  = 12'h300;
  localparam logic [11:0] WIN_RD_LO  = 12'h300;
  localparam logic [11:0] WIN_RD_HI  = 12'h500;
  localparam logic [11:0] IRQ_WIN_HI = 12'h320;
  localparam logic [11:0] IRQ_LAST   = 12'h31C;

  localparam logic [8:0]  RD_ADV_OFS   = 9'h1FE;
  localparam logic [31:0] PTR_STEP     = 32'h0000_0200;
  localparam int          FW_LIMIT     = 32'h000F_F020;
  localparam logic [7:0]  STATUS_VAL   = 8'h80;
  localparam logic [15:0] FW_STATUS    = 16'h0010;
  localparam logic [15:0] PARAM_WIN_A  = 16'h0009;
  localparam logic [15:0] PARAM_WIN_B  = 16'h000A;
  localparam logic [7:0]  BOOT_DELAY_RST   = 8'd240;
  localparam logic [7:0]  IRQ_INTERVAL_RST = 8'd120;
  localparam logic [2:0]  NUM_CHECKS   = 3'd5;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_CHECK = 2'd1,
    SEQ_DONE  = 2'd2
  } seq_state_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM
  } ctrl_state_t;

  typedef struct packed {
    logic accept;      // take the presented transaction, update state
    logic load_out;    // result computed directly, load output register
    logic mem_capture; // load output register from firmware memory
    logic clr_we;      // clearing pass writes one entry
  } ctrl_cmd_t;

  typedef struct packed {
    logic mem_read;    // presented transaction reads the firmware memory
    logic clr_last;    // clearing pass on its final entry
  } dp_status_t;

  function automatic logic [31:0] check_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h8000_0100;
      3'd1:    w = 32'h4000_8000;
      3'd2:    w = 32'h4080_0000;
      3'd3:    w = 32'h8000_0100;
      3'd4:    w = 32'h4000_0200;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/cfpi_ram.sv -----
`timescale 1ns / 1ps

module cfpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/cfpi_ctrl.sv -----
`timescale 1ns / 1ps

module cfpi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  cfpi_pkg::dp_status_t  status,
  output cfpi_pkg::ctrl_cmd_t   cmd
);

  cfpi_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfpi_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cfpi_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) begin
          state_nxt = cfpi_pkg::ST_IDLE;
        end
      end
      cfpi_pkg::ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          cmd.accept = 1'b1;
          if (status.mem_read) begin
            state_nxt = cfpi_pkg::ST_MEM;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      cfpi_pkg::ST_MEM: begin
        // memory data is held until the output register frees up
        if (out_free) begin
          cmd.mem_capture = 1'b1;
          state_nxt       = cfpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfpi_pkg::ST_IDLE;
      end
    endcase

    if (cmd.load_out || cmd.mem_capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- sv/cfpi_dp.sv -----
`timescale 1ns / 1ps

module cfpi_dp #(
  parameter int FIRMWARE_BYTES = 1048576
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [23:0]                       in_tdata,
  output logic [15:0]                       out_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_wdata,
  input  cfpi_pkg::ctrl_cmd_t               cmd,
  output cfpi_pkg::dp_status_t              status,
  output logic                              ram_we,
  output logic                              ram_re,
  output logic [$clog2(FIRMWARE_BYTES)-1:0] ram_addr,
  output logic [7:0]                        ram_wdata,
  input  logic [7:0]                        ram_rdata
);

  localparam int AW     = $clog2(FIRMWARE_BYTES);
  localparam int FW_END = (FIRMWARE_BYTES < cfpi_pkg::FW_LIMIT) ?
                          FIRMWARE_BYTES : cfpi_pkg::FW_LIMIT;
  localparam logic [AW-1:0] CLR_LAST = AW'(FIRMWARE_BYTES - 1);

  logic [1:0]  in_cmd;
  logic [11:0] in_addr;
  logic [7:0]  in_wd;

  logic [7:0]  boot_delay_r, boot_delay_nxt;
  logic [7:0]  irq_interval_r, irq_interval_nxt;
  logic [31:0] ptr_r, ptr_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] param_r, param_nxt;
  logic [7:0]  delay_r, delay_nxt;
  cfpi_pkg::seq_state_t seq_r, seq_nxt;
  logic [2:0]  chk_idx_r, chk_idx_nxt;
  logic [31:0] irq_word_r, irq_word_nxt;
  logic        pending_r, pending_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [7:0]  out_rd_r;
  logic        out_irq_r;

  logic        win_en, in_wwin, in_rwin, in_irqwin;
  logic [11:0] wr_off_full, rd_off_full;
  logic [8:0]  off;
  logic [32:0] idx_sum;
  logic        idx_ok;
  logic        mem_read, mem_write;
  logic [7:0]  rd_byte;
  logic        tick_irq;
  logic [31:0] word_sel;

  assign in_cmd  = in_tdata[1:0];
  assign in_addr = in_tdata[13:2];
  assign in_wd   = in_tdata[21:14];

  assign win_en    = (param_r == cfpi_pkg::PARAM_WIN_A) || (param_r == cfpi_pkg::PARAM_WIN_B);
  assign in_wwin   = (in_addr >= cfpi_pkg::WIN_WR_LO) && (in_addr < cfpi_pkg::WIN_WR_HI);
  assign in_rwin   = (in_addr >= cfpi_pkg::WIN_RD_LO) && (in_addr < cfpi_pkg::WIN_RD_HI);
  assign in_irqwin = pending_r && (in_addr >= cfpi_pkg::WIN_RD_LO) &&
                     (in_addr < cfpi_pkg::IRQ_WIN_HI);

  assign wr_off_full = in_addr - cfpi_pkg::WIN_WR_LO;
  assign rd_off_full = in_addr - cfpi_pkg::WIN_RD_LO;
  assign off         = (in_cmd == cfpi_pkg::CMD_READ) ? rd_off_full[8:0] : wr_off_full[8:0];
  assign idx_sum     = {1'b0, ptr_r} + {24'd0, off};
  assign idx_ok      = idx_sum < 33'(FW_END);

  assign mem_read  = (in_cmd == cfpi_pkg::CMD_READ) && !in_irqwin && in_rwin && win_en && idx_ok;
  assign mem_write = (in_cmd == cfpi_pkg::CMD_WRITE) && in_wwin && win_en && idx_ok;

  assign status.mem_read = mem_read;
  assign status.clr_last = (clr_cnt_r == CLR_LAST);

  assign ram_we    = cmd.clr_we || (cmd.accept && mem_write);
  assign ram_re    = cmd.accept && mem_read;
  assign ram_addr  = cmd.clr_we ? clr_cnt_r : idx_sum[AW-1:0];
  assign ram_wdata = cmd.clr_we ? 8'd0 : in_wd;

  assign word_sel = (in_addr[4:2] == 3'd0) ? irq_word_r : 32'd0;

  // register and interrupt-word reads
  always_comb begin
    rd_byte = 8'd0;
    if (in_addr == cfpi_pkg::OFS_STAT) begin
      rd_byte = cfpi_pkg::STATUS_VAL;
    end else if (in_addr == cfpi_pkg::OFS_PAR_LO) begin
      rd_byte = param_r[7:0];
    end else if (in_addr == cfpi_pkg::OFS_PAR_HI) begin
      rd_byte = param_r[15:8];
    end else if (in_addr == cfpi_pkg::OFS_FST_LO) begin
      rd_byte = cfpi_pkg::FW_STATUS[7:0];
    end else if (in_addr == cfpi_pkg::OFS_FST_HI) begin
      rd_byte = cfpi_pkg::FW_STATUS[15:8];
    end
    if (in_irqwin) begin
      case (in_addr[1:0])
        2'd0:    rd_byte = word_sel[7:0];
        2'd1:    rd_byte = word_sel[15:8];
        2'd2:    rd_byte = word_sel[23:16];
        2'd3:    rd_byte = word_sel[31:24];
        default: rd_byte = 8'd0;
      endcase
    end
  end

  always_comb begin
    boot_delay_nxt   = boot_delay_r;
    irq_interval_nxt = irq_interval_r;
    ptr_nxt          = ptr_r;
    phase_nxt        = phase_r;
    param_nxt        = param_r;
    delay_nxt        = delay_r;
    seq_nxt          = seq_r;
    chk_idx_nxt      = chk_idx_r;
    irq_word_nxt     = irq_word_r;
    pending_nxt      = pending_r;
    tick_irq         = 1'b0;

    // tick sequencer, evaluated for the presented transaction
    if (in_cmd == cfpi_pkg::CMD_TICK) begin
      if (delay_r != 8'd0) begin
        delay_nxt = delay_r - 8'd1;
      end
      if (delay_nxt == 8'd0) begin
        if (seq_r == cfpi_pkg::SEQ_IDLE) begin
          seq_nxt     = cfpi_pkg::SEQ_CHECK;
          chk_idx_nxt = 3'd0;
        end
        if (seq_nxt == cfpi_pkg::SEQ_CHECK) begin
          tick_irq = 1'b1;
          if (chk_idx_nxt >= cfpi_pkg::NUM_CHECKS) begin
            seq_nxt   = cfpi_pkg::SEQ_DONE;
            delay_nxt = 8'd0;
          end else begin
            irq_word_nxt = cfpi_pkg::check_word(chk_idx_nxt);
            chk_idx_nxt  = chk_idx_nxt + 3'd1;
            delay_nxt    = irq_interval_r;
            pending_nxt  = 1'b1;
          end
        end
      end
    end

    if (in_cmd == cfpi_pkg::CMD_WRITE) begin
      if ((in_addr == cfpi_pkg::OFS_PTR_LO) || (in_addr == cfpi_pkg::OFS_PTR_HI)) begin
        case ({phase_r[1], in_addr[0]})
          2'b00:   ptr_nxt[7:0]   = in_wd;
          2'b01:   ptr_nxt[15:8]  = in_wd;
          2'b10:   ptr_nxt[23:16] = in_wd;
          2'b11:   ptr_nxt[31:24] = in_wd;
          default: ptr_nxt = ptr_r;
        endcase
        phase_nxt = phase_r + 2'd1;
      end else if (in_addr == cfpi_pkg::OFS_PAR_LO) begin
        param_nxt[7:0] = in_wd;
      end else if (in_addr == cfpi_pkg::OFS_PAR_HI) begin
        param_nxt[15:8] = in_wd;
      end
    end

    if (in_cmd == cfpi_pkg::CMD_READ) begin
      if (in_irqwin && (in_addr == cfpi_pkg::IRQ_LAST)) begin
        pending_nxt = 1'b0;
      end
      if (mem_read && (rd_off_full[8:0] == cfpi_pkg::RD_ADV_OFS)) begin
        ptr_nxt = ptr_r + cfpi_pkg::PTR_STEP;
      end
    end

    if (!cmd.accept) begin
      ptr_nxt      = ptr_r;
      phase_nxt    = phase_r;
      param_nxt    = param_r;
      delay_nxt    = delay_r;
      seq_nxt      = seq_r;
      chk_idx_nxt  = chk_idx_r;
      irq_word_nxt = irq_word_r;
      pending_nxt  = pending_r;
    end

    // the user must make configuration writes only while no transaction is in flight; the block does not enforce it
    if (cfg_we) begin
      if (cfg_index == cfpi_pkg::REG_BOOT_DELAY) begin
        boot_delay_nxt = cfg_wdata;
        if (seq_r == cfpi_pkg::SEQ_IDLE) begin
          delay_nxt = cfg_wdata;
        end
      end else begin
        irq_interval_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_delay_r   <= cfpi_pkg::BOOT_DELAY_RST;
      irq_interval_r <= cfpi_pkg::IRQ_INTERVAL_RST;
      ptr_r          <= '0;
      phase_r        <= '0;
      param_r        <= '0;
      delay_r        <= cfpi_pkg::BOOT_DELAY_RST;
      seq_r          <= cfpi_pkg::SEQ_IDLE;
      chk_idx_r      <= '0;
      irq_word_r     <= '0;
      pending_r      <= 1'b0;
      clr_cnt_r      <= '0;
    end else begin
      boot_delay_r   <= boot_delay_nxt;
      irq_interval_r <= irq_interval_nxt;
      ptr_r          <= ptr_nxt;
      phase_r        <= phase_nxt;
      param_r        <= param_nxt;
      delay_r        <= delay_nxt;
      seq_r          <= seq_nxt;
      chk_idx_r      <= chk_idx_nxt;
      irq_word_r     <= irq_word_nxt;
      pending_r      <= pending_nxt;
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // output register, payload only
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rd_r  <= (in_cmd == cfpi_pkg::CMD_READ) ? rd_byte : 8'd0;
      out_irq_r <= tick_irq;
    end else if (cmd.mem_capture) begin
      out_rd_r  <= ram_rdata;
      out_irq_r <= 1'b0;
    end
  end

  assign out_tdata = {7'd0, out_irq_r, out_rd_r};

endmodule

// ----- sv/cartridge_firmware_port_with_irq.sv -----
`timescale 1ns / 1ps

// Byte-wide cartridge firmware port with a card-check interrupt sequencer.
// Each transaction is a bus read, a bus write or a frame tick and gives one
// result. Writes, ticks and register reads load the output register
// directly; a read that hits the firmware window goes through the MEM state,
// as the firmware memory has a registered read port, and in_tready stays low
// in that state while the memory data waits to be captured. A new
// transaction is taken only when the output register is empty or is being
// emptied in the same cycle. After reset the firmware memory is cleared one
// byte a cycle, every byte in turn; in_tready stays low during the clearing
// pass, while configuration writes are taken throughout.
module cartridge_firmware_port_with_irq #(
  parameter int FIRMWARE_BYTES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[1:0], address[13:2], write_data[21:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], irq_request[8]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int AW = $clog2(FIRMWARE_BYTES);

  cfpi_pkg::ctrl_cmd_t  cmd;
  cfpi_pkg::dp_status_t status;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;

  cfpi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  cfpi_dp #(
    .FIRMWARE_BYTES (FIRMWARE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

  cfpi_ram #(
    .WIDTH (8),
    .DEPTH (FIRMWARE_BYTES)
  ) u_fw_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // a transaction is only taken when the output register has room
  a_in_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> (!out_tvalid || out_tready))
    else $error("input taken while output register full");

  // an interrupt result never carries read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tdata[7:0] == 8'd0))
    else $error("irq result with nonzero read data");

  // single-port memory: never read and written together
  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("firmware memory read and write in one cycle");

  // a memory read is followed by its capture or a stall, never a new transaction
  a_mem_read_gap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> !(in_tvalid && in_tready))
    else $error("transaction taken while memory read outstanding");

endmodule

// ----- bench/tb_cartridge_firmware_port_with_irq.sv -----
`timescale 1ns / 1ps

module tb_cartridge_firmware_port_with_irq;

  localparam int          FIRMWARE_BYTES = 1048576;
  localparam logic [1:0]  CMD_NOP        = 2'd3;
  localparam int          STALL_LIMIT    = 3200000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          PHASE_ITEMS    = 300;
  localparam int          NUM_PHASES     = 5;
  localparam int          NUM_VECS       = 25;

  localparam logic [31:0] CARD_CHECK_WORDS [5] = '{
    32'h8000_0100, 32'h4000_8000, 32'h4080_0000, 32'h8000_0100, 32'h4000_0200
  };

  // boot delay / interrupt interval per random phase
  localparam logic [7:0] PHASE_BOOT [NUM_PHASES] = '{8'd255, 8'd1, 8'd90, 8'd1, 8'd200};
  localparam logic [7:0] PHASE_GAP  [NUM_PHASES] = '{8'd8, 8'd15, 8'd1, 8'd255, 8'd6};

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } port_result_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [7:0]  data;
    bit          fixed;
    logic [7:0]  want_rd;
    logic        want_irq;
  } bus_vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // command[1:0], address[13:2], write_data[21:14]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // read_data[7:0], irq_request[8]
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // predicted device state
  logic [7:0]  fw_bytes [int];
  logic [31:0] fw_ptr = '0;
  logic [1:0]  ptr_phase = '0;
  logic [15:0] acc_param = '0;
  logic [7:0]  interval_reg = cfpi_pkg::IRQ_INTERVAL_RST;
  logic [7:0]  delay_cnt = cfpi_pkg::BOOT_DELAY_RST;
  cfpi_pkg::seq_state_t seq_st = cfpi_pkg::SEQ_IDLE;
  logic [2:0]  check_idx = '0;
  logic [31:0] irq_word = '0;
  logic        irq_pending = 1'b0;

  port_result_t predicted_results [$];
  int           err_count = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;
  logic [8:0]   last_wr_base = '0;

  bus_vec_t directed_vecs [NUM_VECS] = '{
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::OFS_STAT,   8'h00, 1'b1, 8'h80, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::OFS_FST_LO, 8'h00, 1'b1, 8'h10, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::OFS_FST_HI, 8'h00, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::OFS_PAR_LO, 8'h00, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  12'hFFF,              8'h00, 1'b1, 8'h00, 1'b0},
    '{CMD_NOP,             cfpi_pkg::OFS_STAT,   8'hFF, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_LO, 8'h09, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_HI, 8'hFF, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::OFS_PAR_HI, 8'h00, 1'b1, 8'hFF, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_HI, 8'h00, 1'b1, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::WIN_WR_LO,  8'hFF, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, 12'h2FF,              8'hA5, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::WIN_RD_LO,  8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  12'h4FF,              8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PTR_LO, 8'h20, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PTR_HI, 8'hF0, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PTR_LO, 8'h0F, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PTR_HI, 8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_WRITE, cfpi_pkg::WIN_WR_LO,  8'h55, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::WIN_RD_LO,  8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_TICK,  12'h000,              8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_TICK,  12'hFFF,              8'hFF, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  12'h303,              8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::IRQ_LAST,   8'h00, 1'b0, 8'h00, 1'b0},
    '{cfpi_pkg::CMD_READ,  cfpi_pkg::WIN_RD_LO,  8'h00, 1'b0, 8'h00, 1'b0}
  };

  cartridge_firmware_port_with_irq i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic bit window_open();
    return acc_param == cfpi_pkg::PARAM_WIN_A || acc_param == cfpi_pkg::PARAM_WIN_B;
  endfunction

  // store index for pointer plus offset, -1 past the firmware bound
  function automatic int fw_slot(logic [11:0] off);
    longint idx;
    idx = {32'd0, fw_ptr} + off;
    if (idx >= cfpi_pkg::FW_LIMIT || idx >= FIRMWARE_BYTES) return -1;
    return int'(idx);
  endfunction

  function automatic logic [7:0] model_read(logic [11:0] addr);
    logic [7:0]  r;
    logic [31:0] word;
    logic [11:0] off;
    int          slot;
    r = '0;
    if (addr == cfpi_pkg::OFS_STAT) r = cfpi_pkg::STATUS_VAL;
    else if (addr == cfpi_pkg::OFS_PAR_LO) r = acc_param[7:0];
    else if (addr == cfpi_pkg::OFS_PAR_HI) r = acc_param[15:8];
    else if (addr == cfpi_pkg::OFS_FST_LO) r = cfpi_pkg::FW_STATUS[7:0];
    else if (addr == cfpi_pkg::OFS_FST_HI) r = cfpi_pkg::FW_STATUS[15:8];
    if (irq_pending && addr >= cfpi_pkg::WIN_RD_LO && addr < cfpi_pkg::IRQ_WIN_HI) begin
      word = (addr[4:2] == 3'd0) ? irq_word : 32'd0;
      if (addr == cfpi_pkg::IRQ_LAST) irq_pending = 1'b0;
      r = word[8*addr[1:0] +: 8];
    end else if (addr >= cfpi_pkg::WIN_RD_LO && addr < cfpi_pkg::WIN_RD_HI &&
                 window_open()) begin
      off = addr - cfpi_pkg::WIN_RD_LO;
      slot = fw_slot(off);
      if (slot >= 0) begin
        r = fw_bytes.exists(slot) ? fw_bytes[slot] : 8'h00;
        if (off == cfpi_pkg::RD_ADV_OFS) fw_ptr = fw_ptr + cfpi_pkg::PTR_STEP;
      end
    end
    return r;
  endfunction

  function automatic void model_write(logic [11:0] addr, logic [7:0] v);
    int slot;
    int pos;
    if (addr == cfpi_pkg::OFS_PTR_LO || addr == cfpi_pkg::OFS_PTR_HI) begin
      pos = (addr == cfpi_pkg::OFS_PTR_HI ? 1 : 0) + (ptr_phase < 2'd2 ? 0 : 2);
      fw_ptr[8*pos +: 8] = v;
      ptr_phase = ptr_phase + 2'd1;
    end else if (addr == cfpi_pkg::OFS_PAR_LO) begin
      acc_param[7:0] = v;
    end else if (addr == cfpi_pkg::OFS_PAR_HI) begin
      acc_param[15:8] = v;
    end
    if (addr >= cfpi_pkg::WIN_WR_LO && addr < cfpi_pkg::WIN_WR_HI && window_open()) begin
      slot = fw_slot(addr - cfpi_pkg::WIN_WR_LO);
      if (slot >= 0) fw_bytes[slot] = v;
    end
  endfunction

  function automatic logic model_tick();
    if (delay_cnt != 8'd0) begin
      delay_cnt = delay_cnt - 8'd1;
      if (delay_cnt != 8'd0) return 1'b0;
    end
    if (seq_st == cfpi_pkg::SEQ_IDLE) begin
      seq_st = cfpi_pkg::SEQ_CHECK;
      check_idx = '0;
    end
    if (seq_st != cfpi_pkg::SEQ_CHECK) return 1'b0;
    if (check_idx >= cfpi_pkg::NUM_CHECKS) begin
      seq_st = cfpi_pkg::SEQ_DONE;
      delay_cnt = 8'd0;
    end else begin
      irq_word = CARD_CHECK_WORDS[check_idx];
      check_idx = check_idx + 3'd1;
      delay_cnt = interval_reg;
      irq_pending = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic port_result_t predict_port_result(logic [1:0] cmd, logic [11:0] addr,
                                                       logic [7:0] v);
    port_result_t r;
    r = '0;
    case (cmd)
      cfpi_pkg::CMD_READ:  r.rd = model_read(addr);
      cfpi_pkg::CMD_WRITE: model_write(addr, v);
      cfpi_pkg::CMD_TICK:  r.irq = model_tick();
      default: ;
    endcase
    return r;
  endfunction

  task automatic drive_txn(logic [1:0] cmd, logic [11:0] addr, logic [7:0] v);
    int gap;
    if (items_sent % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v, addr, cmd};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic issue(logic [1:0] cmd, logic [11:0] addr, logic [7:0] v);
    drive_txn(cmd, addr, v);
    predicted_results.push_back(predict_port_result(cmd, addr, v));
  endtask

  // hold the sender until every outstanding result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(logic [7:0] boot, logic [7:0] gap_ticks);
    cfg_we    <= 1'b1;
    cfg_index <= cfpi_pkg::REG_BOOT_DELAY;
    cfg_wdata <= boot;
    @(posedge clk);
    cfg_index <= cfpi_pkg::REG_IRQ_INTERVAL;
    cfg_wdata <= gap_ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (seq_st == cfpi_pkg::SEQ_IDLE) delay_cnt = boot;
    interval_reg = gap_ticks;
  endtask

  task automatic load_pointer();
    logic [31:0] target;
    int          sel;
    int          n;
    sel = $urandom_range(0, 9);
    if (sel < 6) target = $urandom_range(0, 'h3FFF);
    else if (sel < 9) target = cfpi_pkg::FW_LIMIT - $urandom_range(0, 'h400);
    else target = $urandom();
    // a few broken sequences leave the byte phase misaligned
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4;
    repeat (n)
      issue(cfpi_pkg::CMD_WRITE,
            ptr_phase[0] ? cfpi_pkg::OFS_PTR_HI : cfpi_pkg::OFS_PTR_LO,
            target[8*ptr_phase +: 8]);
  endtask

  task automatic load_param();
    logic [15:0] val;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) val = cfpi_pkg::PARAM_WIN_A;
    else if (sel < 8) val = cfpi_pkg::PARAM_WIN_B;
    else val = 16'($urandom());
    if ($urandom_range(0, 1)) begin
      issue(cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_LO, val[7:0]);
      issue(cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_HI, val[15:8]);
    end else begin
      issue(cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_HI, val[15:8]);
      issue(cfpi_pkg::CMD_WRITE, cfpi_pkg::OFS_PAR_LO, val[7:0]);
    end
    if ($urandom_range(0, 3) == 0)
      issue(cfpi_pkg::CMD_READ,
            $urandom_range(0, 1) ? cfpi_pkg::OFS_PAR_HI : cfpi_pkg::OFS_PAR_LO, 8'h00);
  endtask

  task automatic write_window();
    logic [8:0] base;
    int         n;
    base = 9'($urandom());
    n = $urandom_range(1, 8);
    last_wr_base = base;
    for (int i = 0; i < n; i++)
      issue(cfpi_pkg::CMD_WRITE, cfpi_pkg::WIN_WR_LO + 12'(9'(base + i)), 8'($urandom()));
  endtask

  task automatic read_window();
    logic [8:0] base;
    int         n;
    int         sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) base = 9'(cfpi_pkg::RD_ADV_OFS - $urandom_range(0, 4));
    else if (sel == 1) base = 9'($urandom());
    else base = last_wr_base;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      issue(cfpi_pkg::CMD_READ, cfpi_pkg::WIN_RD_LO + 12'(9'(base + i)), 8'($urandom()));
  endtask

  task automatic read_irq_words();
    logic [11:0] addr;
    addr = 12'(cfpi_pkg::WIN_RD_LO + $urandom_range(0, 8));
    while (addr < cfpi_pkg::IRQ_WIN_HI) begin
      issue(cfpi_pkg::CMD_READ, addr, 8'($urandom()));
      if ($urandom_range(0, 15) == 0) break;
      addr = addr + 12'd1;
    end
  endtask

  task automatic random_phase(int target);
    int pick;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (irq_pending && pick < 30) read_irq_words();
      else if (pick < 40) load_pointer();
      else if (pick < 50) load_param();
      else if (pick < 68) write_window();
      else if (pick < 83) read_window();
      else if (pick < 93) repeat ($urandom_range(1, 6))
        issue(cfpi_pkg::CMD_TICK, 12'($urandom()), 8'($urandom()));
      else repeat ($urandom_range(1, 4))
        issue(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)), 8'($urandom()));
    end
  endtask

  initial begin
    port_result_t r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    program_regs(8'd2, 8'd1);

    for (int i = 0; i < NUM_VECS; i++) begin
      drive_txn(directed_vecs[i].cmd, directed_vecs[i].addr, directed_vecs[i].data);
      r = predict_port_result(directed_vecs[i].cmd, directed_vecs[i].addr,
                              directed_vecs[i].data);
      if (directed_vecs[i].fixed) begin
        r.rd  = directed_vecs[i].want_rd;
        r.irq = directed_vecs[i].want_irq;
      end
      predicted_results.push_back(r);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      program_regs(PHASE_BOOT[p], PHASE_GAP[p]);
      random_phase(NUM_VECS + (p + 1) * PHASE_ITEMS);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && predicted_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // result sink with random back-pressure
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
      taken++;
    end
  end

  always @(posedge clk) begin : check_results
    port_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_tdata);
        err_count++;
      end else begin
        want = predicted_results.pop_front();
        if (want.rd !== out_tdata[7:0]) begin
          $display("%0t: read_data expected %h actual %h", $time, want.rd, out_tdata[7:0]);
          err_count++;
        end
        if (want.irq !== out_tdata[8]) begin
          $display("%0t: irq_request expected %b actual %b", $time, want.irq, out_tdata[8]);
          err_count++;
        end
      end
    end
  end

  // covers the firmware clearing pass after reset
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
